FILE: rtl/core/ptu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer table update: shared package
// Types, codes and constants used by the peer table core and its interfaces.
// ----------------------------------------------------------------------------
package ptu_pkg;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 64;

  localparam logic [15:0] SEQ_HALF    = 16'h8000;
  localparam logic [31:0] AGE_UNKNOWN = 32'hFFFF_FFFF;

  localparam logic [63:0] OWN_ID_RST        = 64'd0;
  localparam logic [31:0] STALE_TIMEOUT_RST = 32'd30000;
  localparam logic [31:0] LOST_TIMEOUT_RST  = 32'd300000;
  localparam logic [31:0] MAX_FIX_AGE_RST   = 32'd60;

  typedef enum logic {
    ACT_PACKET = 1'b0,
    ACT_TICK   = 1'b1
  } ptu_action_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_INVALID   = 3'd1,
    ST_SELF      = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4,
    ST_TICK_DONE = 3'd5
  } ptu_status_t;

  typedef enum logic [1:0] {
    CFG_OWN_ID        = 2'd0,
    CFG_STALE_TIMEOUT = 2'd1,
    CFG_LOST_TIMEOUT  = 2'd2,
    CFG_MAX_FIX_AGE   = 2'd3
  } ptu_cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DONE
  } ptu_state_t;

  typedef struct packed {
    logic [63:0] own_id;
    logic [31:0] stale_timeout_ms;
    logic [31:0] lost_timeout_ms;
    logic [31:0] max_fix_age_sec;
  } ptu_cfg_t;

  typedef struct packed {
    ptu_action_t action;
    logic [31:0] now_ms;
    logic [63:0] device_id;
    logic [15:0] sequence_req;
    logic        has_position;
    logic        fix_last_known;
    logic [31:0] age_sec;
    logic        is_sos;
  } ptu_item_t;

  typedef struct packed {
    ptu_status_t status;
    logic [3:0]  slot;
    logic        position_usable;
    logic [4:0]  peer_count;
    logic [31:0] change_count;
  } ptu_result_t;

  // One table entry as held in the peer memory.
  typedef struct packed {
    logic [63:0] peer_id;
    logic [15:0] last_sequence;
    logic        sequence_seen;
    logic [31:0] last_seen_ms;
    logic [31:0] packets_received;
    logic        position_valid;
    logic        sos_active;
    logic [31:0] position_age;
  } ptu_entry_t;

  // Ids compare as strings: everything from the first zero byte on is cleared.
  function automatic logic [63:0] norm_id(input logic [63:0] id);
    logic [63:0] res;
    logic        zero_seen;
    res       = id;
    zero_seen = 1'b0;
    for (int k = 7; k >= 0; k--) begin
      if (id[8*k +: 8] == 8'h00) zero_seen = 1'b1;
      if (zero_seen) res[8*k +: 8] = 8'h00;
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/ptu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer table update: input channel
// Valid/ready channel carrying one packet or tick item per transfer.
// ----------------------------------------------------------------------------
interface ptu_in_if;
  import ptu_pkg::*;

  logic        valid;
  logic        ready;
  ptu_action_t action;
  logic [31:0] now_ms;
  logic [63:0] device_id;
  logic [15:0] sequence_req;
  logic        has_position;
  logic        fix_last_known;
  logic [31:0] age_sec;
  logic        is_sos;

  modport source (
    output valid, action, now_ms, device_id, sequence_req, has_position,
           fix_last_known, age_sec, is_sos,
    input  ready
  );

  modport sink (
    input  valid, action, now_ms, device_id, sequence_req, has_position,
           fix_last_known, age_sec, is_sos,
    output ready
  );
endinterface

FILE: rtl/core/ptu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer table update: result channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface ptu_out_if;
  import ptu_pkg::*;

  logic        valid;
  logic        ready;
  ptu_status_t status;
  logic [3:0]  slot;
  logic        position_usable;
  logic [4:0]  peer_count;
  logic [31:0] change_count;

  modport source (
    output valid, status, slot, position_usable, peer_count, change_count,
    input  ready
  );

  modport sink (
    input  valid, status, slot, position_usable, peer_count, change_count,
    output ready
  );
endinterface

FILE: rtl/core/ptu_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer table update: configuration registers
// APB-style register file holding the own id and the three time limits.
// ----------------------------------------------------------------------------
module ptu_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptu_pkg::CFG_AW-1:0]   paddr,
  input  logic [ptu_pkg::CFG_DW-1:0]   pwdata,
  output logic [ptu_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready,
  output ptu_pkg::ptu_cfg_t            cfg
);
  import ptu_pkg::*;

  logic [63:0]  own_id_r;
  logic [31:0]  stale_timeout_r;
  logic [31:0]  lost_timeout_r;
  logic [31:0]  max_fix_age_r;
  logic         wr_en;
  ptu_cfg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  // Registers sit on eight-byte boundaries.
  assign reg_idx = ptu_cfg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r        <= OWN_ID_RST;
      stale_timeout_r <= STALE_TIMEOUT_RST;
      lost_timeout_r  <= LOST_TIMEOUT_RST;
      max_fix_age_r   <= MAX_FIX_AGE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        CFG_OWN_ID:        own_id_r        <= pwdata;
        CFG_STALE_TIMEOUT: stale_timeout_r <= pwdata[31:0];
        CFG_LOST_TIMEOUT:  lost_timeout_r  <= pwdata[31:0];
        CFG_MAX_FIX_AGE:   max_fix_age_r   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      CFG_OWN_ID:        prdata = own_id_r;
      CFG_STALE_TIMEOUT: prdata = {32'd0, stale_timeout_r};
      CFG_LOST_TIMEOUT:  prdata = {32'd0, lost_timeout_r};
      CFG_MAX_FIX_AGE:   prdata = {32'd0, max_fix_age_r};
      default:           prdata = '0;
    endcase
  end

  assign cfg.own_id           = own_id_r;
  assign cfg.stale_timeout_ms = stale_timeout_r;
  assign cfg.lost_timeout_ms  = lost_timeout_r;
  assign cfg.max_fix_age_sec  = max_fix_age_r;

endmodule

FILE: rtl/core/ptu_peer_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer table update: peer memory
// One-write, one-read synchronous memory of table entries, registered read.
// ----------------------------------------------------------------------------
module ptu_peer_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output ptu_pkg::ptu_entry_t  rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  ptu_pkg::ptu_entry_t  wr_data
);
  import ptu_pkg::*;

  ptu_entry_t mem [DEPTH];
  ptu_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/ptu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer table update: table controller
// Scans the peer memory once per item, picks and writes the slot for a packet.
// ----------------------------------------------------------------------------
module ptu_ctrl #(
  parameter int unsigned PEER_SLOTS = 16,
  parameter int unsigned IDXW       = 4,
  parameter int unsigned CNTW       = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ptu_pkg::ptu_cfg_t     cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ptu_pkg::ptu_item_t    in_item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ptu_pkg::ptu_result_t  res,
  output logic                  mem_rd_en,
  output logic [IDXW-1:0]       mem_rd_addr,
  input  ptu_pkg::ptu_entry_t   mem_rd_data,
  output logic                  mem_we,
  output logic [IDXW-1:0]       mem_wr_addr,
  output ptu_pkg::ptu_entry_t   mem_wr_data
);
  import ptu_pkg::*;

  ptu_state_t            state_r, state_nxt;
  logic [CNTW-1:0]       issue_r, issue_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [IDXW-1:0]       chk_idx_r;
  logic [PEER_SLOTS-1:0] used_r, used_nxt;
  logic [CNTW-1:0]       occ_r, occ_nxt;
  logic [31:0]           changes_r, changes_nxt;
  logic                  found_r, found_nxt;
  logic                  lost_fnd_r, lost_fnd_nxt;
  logic                  stale_fnd_r, stale_fnd_nxt;
  logic                  freed_r, freed_nxt;

  ptu_item_t             item_r;
  logic [63:0]           id_r;
  logic                  empty_r;
  logic                  self_r;
  logic [IDXW-1:0]       match_idx_r;
  ptu_entry_t            match_ent_r;
  logic [IDXW-1:0]       lost_idx_r;
  logic [IDXW-1:0]       stale_idx_r;
  logic [31:0]           stale_best_r;
  ptu_result_t           res_r, res_nxt;
  logic [IDXW-1:0]       res_idx_r;

  logic                  accept_in;
  logic                  issuing;
  logic [31:0]           elapsed;
  logic                  ent_used;
  logic                  seen_nz;
  logic                  ent_lost;
  logic                  ent_stale;
  logic                  ent_match;
  logic                  take_match;
  logic                  take_lost;
  logic                  take_stale;
  logic                  free_fnd;
  logic [IDXW-1:0]       free_idx;
  logic [15:0]           seq_diff;
  logic                  newer;
  logic                  have_tgt;
  logic                  fresh;
  logic [IDXW-1:0]       tgt_idx;
  logic                  store;
  logic                  too_old;
  logic                  pos_ok;
  ptu_status_t           pkt_status;
  logic [IDXW+3:0]       slot_wide;
  logic [CNTW+4:0]       cnt_wide;

  assign in_ready  = (state_r == S_IDLE);
  assign accept_in = in_valid & in_ready;
  assign issuing   = (issue_r < CNTW'(PEER_SLOTS));
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  assign mem_rd_en   = (state_r == S_SCAN) & issuing;
  assign mem_rd_addr = issue_r[IDXW-1:0];

  // Per-entry checks on the word read in the previous cycle.
  always_comb begin
    elapsed    = item_r.now_ms - mem_rd_data.last_seen_ms;
    ent_used   = used_r[chk_idx_r];
    seen_nz    = |mem_rd_data.last_seen_ms;
    ent_lost   = chk_vld_r & ent_used & seen_nz & (elapsed >= cfg.lost_timeout_ms);
    ent_stale  = chk_vld_r & ent_used &
                 (!seen_nz | (elapsed >= cfg.stale_timeout_ms));
    ent_match  = chk_vld_r & ent_used & (item_r.action == ACT_PACKET) &
                 (mem_rd_data.peer_id == id_r);
    take_match = ent_match & !found_r;
    take_lost  = ent_lost & !lost_fnd_r;
    take_stale = ent_stale &
                 (!stale_fnd_r | (mem_rd_data.last_seen_ms < stale_best_r));
  end

  // Lowest free slot, straight from the occupancy flags.
  always_comb begin
    free_fnd = 1'b0;
    free_idx = '0;
    for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_fnd = 1'b1;
        free_idx = IDXW'(i);
      end
    end
  end

  // Packet decision once the scan is complete.
  always_comb begin
    seq_diff = item_r.sequence_req - match_ent_r.last_sequence;
    newer    = (seq_diff != 16'd0) & (seq_diff < SEQ_HALF);
    have_tgt = 1'b1;
    fresh    = 1'b1;
    tgt_idx  = '0;
    if (found_r) begin
      tgt_idx  = match_idx_r;
      fresh    = 1'b0;
      have_tgt = !(match_ent_r.sequence_seen & !newer);
    end else if (free_fnd) begin
      tgt_idx = free_idx;
    end else if (lost_fnd_r) begin
      tgt_idx = lost_idx_r;
    end else if (stale_fnd_r) begin
      tgt_idx = stale_idx_r;
    end else begin
      have_tgt = 1'b0;
    end

    if (empty_r)                  pkt_status = ST_INVALID;
    else if (self_r)              pkt_status = ST_SELF;
    else if (found_r & !have_tgt) pkt_status = ST_DUPLICATE;
    else if (!have_tgt)           pkt_status = ST_FULL;
    else                          pkt_status = ST_ACCEPTED;
    store = (pkt_status == ST_ACCEPTED);

    too_old = item_r.has_position & item_r.fix_last_known &
              ((item_r.age_sec == AGE_UNKNOWN) | (item_r.age_sec > cfg.max_fix_age_sec));
    pos_ok  = item_r.has_position & !too_old;

    mem_wr_data.peer_id          = id_r;
    mem_wr_data.last_sequence    = item_r.sequence_req;
    mem_wr_data.sequence_seen    = 1'b1;
    mem_wr_data.last_seen_ms     = item_r.now_ms;
    mem_wr_data.packets_received = (fresh ? 32'd0 : match_ent_r.packets_received) + 32'd1;
    mem_wr_data.position_valid   = pos_ok;
    mem_wr_data.sos_active       = item_r.is_sos;
    mem_wr_data.position_age     = item_r.age_sec;
  end

  assign mem_we      = (state_r == S_DECIDE) & (item_r.action == ACT_PACKET) & store;
  assign mem_wr_addr = tgt_idx;

  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    chk_vld_nxt   = 1'b0;
    used_nxt      = used_r;
    occ_nxt       = occ_r;
    changes_nxt   = changes_r;
    found_nxt     = found_r;
    lost_fnd_nxt  = lost_fnd_r;
    stale_fnd_nxt = stale_fnd_r;
    freed_nxt     = freed_r;
    res_nxt       = res_r;
    slot_wide     = '0;
    cnt_wide      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          issue_nxt     = '0;
          found_nxt     = 1'b0;
          lost_fnd_nxt  = 1'b0;
          stale_fnd_nxt = 1'b0;
          freed_nxt     = 1'b0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issuing) issue_nxt = issue_r + CNTW'(1);
        chk_vld_nxt = issuing;
        if (take_match) found_nxt = 1'b1;
        if (take_lost)  lost_fnd_nxt = 1'b1;
        if (take_stale) stale_fnd_nxt = 1'b1;
        // A tick frees lost peers as the scan passes them.
        if ((item_r.action == ACT_TICK) & ent_lost) begin
          used_nxt[chk_idx_r] = 1'b0;
          occ_nxt             = occ_r - CNTW'(1);
          freed_nxt           = 1'b1;
        end
        if (!issuing & !chk_vld_r) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (item_r.action == ACT_TICK) begin
          changes_nxt = changes_r + {31'd0, freed_r};
          res_nxt.status          = ST_TICK_DONE;
          res_nxt.position_usable = 1'b0;
        end else begin
          if (store) begin
            changes_nxt       = changes_r + 32'd1;
            used_nxt[tgt_idx] = 1'b1;
            if (!used_r[tgt_idx]) occ_nxt = occ_r + CNTW'(1);
            slot_wide = (IDXW + 4)'(tgt_idx);
          end
          res_nxt.status          = pkt_status;
          res_nxt.position_usable = store & pos_ok;
        end
        cnt_wide             = (CNTW + 5)'(occ_nxt);
        res_nxt.slot         = slot_wide[3:0];
        res_nxt.peer_count   = cnt_wide[4:0];
        res_nxt.change_count = changes_nxt;
        state_nxt            = S_DONE;
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= '0;
      chk_vld_r   <= 1'b0;
      used_r      <= '0;
      occ_r       <= '0;
      changes_r   <= '0;
      found_r     <= 1'b0;
      lost_fnd_r  <= 1'b0;
      stale_fnd_r <= 1'b0;
      freed_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      chk_vld_r   <= chk_vld_nxt;
      used_r      <= used_nxt;
      occ_r       <= occ_nxt;
      changes_r   <= changes_nxt;
      found_r     <= found_nxt;
      lost_fnd_r  <= lost_fnd_nxt;
      stale_fnd_r <= stale_fnd_nxt;
      freed_r     <= freed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    chk_idx_r <= mem_rd_addr;
    if (accept_in) begin
      item_r  <= in_item;
      id_r    <= norm_id(in_item.device_id);
      empty_r <= (norm_id(in_item.device_id) == 64'd0);
      self_r  <= (norm_id(in_item.device_id) == norm_id(cfg.own_id));
    end
    if (take_match) begin
      match_idx_r <= chk_idx_r;
      match_ent_r <= mem_rd_data;
    end
    if (take_lost) lost_idx_r <= chk_idx_r;
    if (take_stale) begin
      stale_idx_r  <= chk_idx_r;
      stale_best_r <= mem_rd_data.last_seen_ms;
    end
    if (state_r == S_DECIDE) res_idx_r <= tgt_idx;
  end

`ifndef SYNTH
  a_occ_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == CNTW'($countones(used_r)))
    else $error("occupied count disagrees with slot flags");

  a_check_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (state_r == S_SCAN))
    else $error("memory word checked outside the scan");

  a_accepted_slot_used: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (item_r.action == ACT_PACKET) &&
     (res_r.status == ST_ACCEPTED)) |-> used_r[res_idx_r])
    else $error("accepted packet left its slot unoccupied");

  a_no_write_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (!empty_r && !self_r && (state_r == S_DECIDE)))
    else $error("table written for a rejected packet");
`endif

endmodule

FILE: rtl/core/peer_table_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer table update core
// Keeps a table of remote radio peers and answers each packet or tick item.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Carries
//  in_ch     in         valid / ready    packet or tick item
//  out_ch    out        valid / ready    status, slot, counts
//  cfg_*     in / out   APB write/read   own id and time limits
//
//  Each item is answered after a scan that reads one memory entry a cycle
//  over all PEER_SLOTS entries, followed by the decide and done states.
//  A new item is taken once the previous result sits in the output register.
//  Reset is synchronous and clears the occupancy flags at once; no memory
//  clearing pass is needed. A stalled result holds the output register.
// ----------------------------------------------------------------------------
module peer_table_update_core #(
  parameter int unsigned PEER_SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ptu_in_if.sink                      in_ch,
  ptu_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ptu_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [ptu_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [ptu_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import ptu_pkg::*;

  localparam int unsigned IDXW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int unsigned CNTW = $clog2(PEER_SLOTS + 1);

  ptu_cfg_t    cfg;
  ptu_item_t   item;
  ptu_result_t res;
  logic        res_valid;
  logic        res_ready;
  logic        mem_rd_en;
  logic [IDXW-1:0] mem_rd_addr;
  ptu_entry_t  mem_rd_data;
  logic        mem_we;
  logic [IDXW-1:0] mem_wr_addr;
  ptu_entry_t  mem_wr_data;

  logic        out_valid_r;
  ptu_result_t out_res_r;

  assign item.action         = in_ch.action;
  assign item.now_ms         = in_ch.now_ms;
  assign item.device_id      = in_ch.device_id;
  assign item.sequence_req   = in_ch.sequence_req;
  assign item.has_position   = in_ch.has_position;
  assign item.fix_last_known = in_ch.fix_last_known;
  assign item.age_sec        = in_ch.age_sec;
  assign item.is_sos         = in_ch.is_sos;

  ptu_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ptu_peer_mem #(
    .DEPTH (PEER_SLOTS),
    .AW    (IDXW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  ptu_ctrl #(
    .PEER_SLOTS (PEER_SLOTS),
    .IDXW       (IDXW),
    .CNTW       (CNTW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_item     (item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_we      (mem_we),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  // Output register: the controller hands over a result whenever it is empty
  // or is being emptied by a transfer in the same cycle.
  assign res_ready = !out_valid_r | out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready & res_valid) out_res_r <= res;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_res_r.status;
  assign out_ch.slot            = out_res_r.slot;
  assign out_ch.position_usable = out_res_r.position_usable;
  assign out_ch.peer_count      = out_res_r.peer_count;
  assign out_ch.change_count    = out_res_r.change_count;

endmodule
